[rtl/core/bilinear_integer_upscaler_defines.svh]
// ----------------------------------------------------------------------------
// Bilinear integer upscaler: assertion macros
// Concurrent check macros sampled on clk and disabled while rst_n is low.
// They expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef BILINEAR_INTEGER_UPSCALER_DEFINES_SVH
`define BILINEAR_INTEGER_UPSCALER_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define BIU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define BIU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BIU_ASSERT_IMP(lbl, ante, cons, msg)
`define BIU_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/core/biu_pkg.sv]
// ----------------------------------------------------------------------------
// biu_pkg
// Shared types and constants of the bilinear integer upscaler.
// ----------------------------------------------------------------------------
package biu_pkg;

  localparam int ROW_W     = 10;    // row counter width
  localparam int HEIGHT_LIM = 1024; // largest frame height
  localparam int OFS_W     = 2;     // dx / dy offset width (scale <= 4)
  localparam int CHAN_MAX  = 255;

  // configuration register indexes
  localparam logic [1:0] REG_SCALE  = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EMIT,
    ST_COMMIT
  } biu_state_t;

  // source cell relative to the newest pixel
  typedef enum logic [1:0] {
    CELL_UL,  // (col-1, row-1)
    CELL_UR,  // (col, row-1), right edge
    CELL_LL,  // (col-1, row), bottom edge
    CELL_LR   // (col, row), corner
  } biu_cell_t;

  typedef struct packed {
    logic             capture;  // latch pixel, read line buffer
    logic             commit;   // write line buffer, step counters
    logic             issue;    // push one output point into the pipe
    logic             last;     // final point of the item
    biu_cell_t        quad;
    logic [OFS_W-1:0] dx;
    logic [OFS_W-1:0] dy;
  } biu_cmd_t;

  typedef struct packed {
    logic       row_nz;
    logic       col_nz;
    logic       last_col;
    logic       last_row;
    logic       adv;     // pipeline moves this cycle
    logic [2:0] scale;   // clamped scale factor
  } biu_stat_t;

endpackage

[rtl/core/biu_ctrl.sv]
// ----------------------------------------------------------------------------
// biu_ctrl
// Sequencer: per input item, walks the applicable cells and their dy/dx
// offsets and issues one output point per cycle to the datapath while its pipe moves.
// ----------------------------------------------------------------------------
module biu_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  biu_pkg::biu_stat_t stat,
  output biu_pkg::biu_cmd_t  cmd
);

  biu_pkg::biu_state_t state_r, state_nxt;
  biu_pkg::biu_cell_t  cell_r, cell_nxt;
  logic [3:0]                  mask_r, mask_nxt;
  logic [biu_pkg::OFS_W-1:0]   dx_r, dx_nxt;
  logic [biu_pkg::OFS_W-1:0]   dy_r, dy_nxt;

  logic [3:0] fetch_mask;
  logic [3:0] rem_mask;
  logic       dx_end;
  logic       dy_end;
  logic       accept;

  function automatic biu_pkg::biu_cell_t first_cell(input logic [3:0] m);
    biu_pkg::biu_cell_t c;
    c = biu_pkg::CELL_LR;
    if (m[0]) c = biu_pkg::CELL_UL;
    else if (m[1]) c = biu_pkg::CELL_UR;
    else if (m[2]) c = biu_pkg::CELL_LL;
    return c;
  endfunction

  assign accept     = in_valid && !in_stall;
  assign fetch_mask = {stat.last_row & stat.last_col, stat.last_row & stat.col_nz,
                       stat.row_nz & stat.last_col, stat.row_nz & stat.col_nz};
  // cells still pending after the current one
  assign rem_mask   = mask_r & (4'b1110 << cell_r);
  assign dx_end     = ({1'b0, dx_r} == stat.scale - 3'd1);
  assign dy_end     = ({1'b0, dy_r} == stat.scale - 3'd1);

  // next state
  always_comb begin
    state_nxt = state_r;
    cell_nxt  = cell_r;
    mask_nxt  = mask_r;
    dx_nxt    = dx_r;
    dy_nxt    = dy_r;
    unique case (state_r)
      biu_pkg::ST_IDLE: begin
        if (accept) state_nxt = biu_pkg::ST_FETCH;
      end
      biu_pkg::ST_FETCH: begin
        mask_nxt = fetch_mask;
        cell_nxt = first_cell(fetch_mask);
        dx_nxt   = '0;
        dy_nxt   = '0;
        state_nxt = (fetch_mask == 4'd0) ? biu_pkg::ST_COMMIT : biu_pkg::ST_EMIT;
      end
      biu_pkg::ST_EMIT: begin
        if (stat.adv) begin
          if (!dx_end) begin
            dx_nxt = dx_r + biu_pkg::OFS_W'(1);
          end else begin
            dx_nxt = '0;
            if (!dy_end) begin
              dy_nxt = dy_r + biu_pkg::OFS_W'(1);
            end else begin
              dy_nxt = '0;
              if (rem_mask == 4'd0) state_nxt = biu_pkg::ST_COMMIT;
              else cell_nxt = first_cell(rem_mask);
            end
          end
        end
      end
      biu_pkg::ST_COMMIT: begin
        state_nxt = biu_pkg::ST_IDLE;
      end
      default: state_nxt = biu_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall    = 1'b1;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    cmd.issue   = 1'b0;
    cmd.last    = 1'b0;
    cmd.quad    = cell_r;
    cmd.dx      = dx_r;
    cmd.dy      = dy_r;
    unique case (state_r)
      biu_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      biu_pkg::ST_FETCH: ;
      biu_pkg::ST_EMIT: begin
        cmd.issue = stat.adv;
        cmd.last  = dx_end && dy_end && (rem_mask == 4'd0);
      end
      biu_pkg::ST_COMMIT: begin
        cmd.commit = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= biu_pkg::ST_IDLE;
      cell_r  <= biu_pkg::CELL_UL;
      mask_r  <= '0;
      dx_r    <= '0;
      dy_r    <= '0;
    end else begin
      state_r <= state_nxt;
      cell_r  <= cell_nxt;
      mask_r  <= mask_nxt;
      dx_r    <= dx_nxt;
      dy_r    <= dy_nxt;
    end
  end

endmodule

[rtl/core/biu_datapath.sv]
// ----------------------------------------------------------------------------
// biu_datapath
// Configuration registers, frame counters, line buffer, corner pixels and a
// four-stage interpolation pipe ending in the output register.
// ----------------------------------------------------------------------------
module biu_datapath #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_SCALE = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [7:0]         in_red_in,
  input  logic [7:0]         in_green_in,
  input  logic [7:0]         in_blue_in,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [10:0]        cfg_data,
  input  biu_pkg::biu_cmd_t  cmd,
  output biu_pkg::biu_stat_t stat,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [11:0]        out_x,
  output logic [11:0]        out_y,
  output logic [7:0]         out_red_out,
  output logic [7:0]         out_green_out,
  output logic [7:0]         out_blue_out,
  output logic               out_run_last
);

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW    = COL_W + 1;
  localparam int XW    = (COL_W + 4 > 12) ? COL_W + 4 : 12;
  localparam int YW    = biu_pkg::ROW_W + 4;
  localparam int OW    = biu_pkg::OFS_W;

  // ---------------- configuration and counters ----------------
  logic [2:0]  scale_r;
  logic [10:0] width_r;
  logic [10:0] height_r;
  logic [COL_W-1:0]          col_r, col_nxt;
  logic [biu_pkg::ROW_W-1:0] row_r, row_nxt;

  logic [2:0]                s_eff;
  logic [WW-1:0]             w_eff;
  logic [10:0]               h_eff;
  logic [COL_W-1:0]          col_cur;
  logic [biu_pkg::ROW_W-1:0] row_cur;
  logic [WW-1:0]             col_inc;
  logic [10:0]               row_inc;
  logic                      adv;

  always_comb begin
    if (scale_r < 3'd2) s_eff = 3'd2;
    else if (int'(scale_r) > MAX_SCALE) s_eff = 3'(MAX_SCALE);
    else s_eff = scale_r;

    if (width_r == 11'd0) w_eff = WW'(1);
    else if (int'(width_r) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(width_r);

    if (height_r == 11'd0) h_eff = 11'd1;
    else if (int'(height_r) > biu_pkg::HEIGHT_LIM) h_eff = 11'(biu_pkg::HEIGHT_LIM);
    else h_eff = height_r;
  end

  assign col_cur = ({1'b0, col_r} >= w_eff) ? '0 : col_r;
  assign row_cur = ({1'b0, row_r} >= h_eff) ? '0 : row_r;
  assign col_inc = {1'b0, col_cur} + WW'(1);
  assign row_inc = {1'b0, row_cur} + 11'd1;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cmd.commit) begin
      if (col_inc >= w_eff) begin
        col_nxt = '0;
        row_nxt = (row_inc >= h_eff) ? '0 : row_inc[biu_pkg::ROW_W-1:0];
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r  <= 3'd2;
      width_r  <= 11'd1024;
      height_r <= 11'd1024;
      col_r    <= '0;
      row_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        biu_pkg::REG_SCALE:  scale_r  <= cfg_data[2:0];
        biu_pkg::REG_WIDTH:  width_r  <= cfg_data;
        biu_pkg::REG_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
      // any write restarts the frame
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------- line buffer and corner pixels ----------------
  logic [23:0] mem [MAX_WIDTH];
  logic [23:0] up_q_r;
  logic [23:0] pix_r;
  logic [23:0] left_r;
  logic [23:0] ul_r;

  always_ff @(posedge clk) begin
    if (cmd.commit) mem[col_cur] <= pix_r;
    if (cmd.capture) up_q_r <= mem[col_cur];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
      ul_r   <= '0;
    end else if (cmd.commit) begin
      left_r <= pix_r;
      ul_r   <= up_q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) pix_r <= {in_red_in, in_green_in, in_blue_in};
  end

  // ---------------- point issue ----------------
  logic [23:0]      c00, c01, c10, c11;
  logic [COL_W-1:0] cx;
  logic [biu_pkg::ROW_W-1:0] cy;
  logic [XW-1:0]    x_full;
  logic [YW-1:0]    y_full;

  always_comb begin
    unique case (cmd.quad)
      biu_pkg::CELL_UL: begin
        c00 = ul_r;   c01 = up_q_r; c10 = left_r; c11 = pix_r;
      end
      biu_pkg::CELL_UR: begin
        c00 = up_q_r; c01 = up_q_r; c10 = pix_r;  c11 = pix_r;
      end
      biu_pkg::CELL_LL: begin
        c00 = left_r; c01 = pix_r;  c10 = left_r; c11 = pix_r;
      end
      biu_pkg::CELL_LR: begin
        c00 = pix_r;  c01 = pix_r;  c10 = pix_r;  c11 = pix_r;
      end
      default: begin
        c00 = pix_r;  c01 = pix_r;  c10 = pix_r;  c11 = pix_r;
      end
    endcase
  end

  assign cx = col_cur - COL_W'(cmd.quad == biu_pkg::CELL_UL || cmd.quad == biu_pkg::CELL_LL);
  assign cy = row_cur -
              biu_pkg::ROW_W'(cmd.quad == biu_pkg::CELL_UL || cmd.quad == biu_pkg::CELL_UR);
  assign x_full = XW'(cx) * XW'(s_eff) + XW'(cmd.dx);
  assign y_full = YW'(cy) * YW'(s_eff) + YW'(cmd.dy);

  // signed division truncating toward zero; |n| <= 765, s in 2..4
  function automatic logic signed [9:0] tdiv(input logic signed [10:0] n,
                                             input logic [2:0] s);
    logic [9:0]  mag;
    logic [19:0] prod;
    logic [9:0]  q;
    logic signed [9:0] qs;
    mag  = n[10] ? 10'(-n) : n[9:0];
    prod = 20'(mag) * 20'd683;  // 683/2048 ~ 1/3, exact below 1024
    case (s)
      3'd3:    q = {1'b0, prod[19:11]};
      3'd4:    q = mag >> 2;
      default: q = mag >> 1;
    endcase
    qs = $signed(q);
    return n[10] ? -qs : qs;
  endfunction

  // ---------------- interpolation pipe ----------------
  assign adv = !out_valid || !out_stall;

  // stage 1: horizontal products
  logic                    s1_v_r, s1_last_r;
  logic [11:0]             s1_x_r, s1_y_r;
  logic [OW-1:0]           s1_dy_r;
  logic [7:0]              s1_a_r [3];
  logic [7:0]              s1_c_r [3];
  logic signed [10:0]      s1_pb_r [3];
  logic signed [10:0]      s1_pd_r [3];
  // stage 2: top and bottom rows
  logic                    s2_v_r, s2_last_r;
  logic [11:0]             s2_x_r, s2_y_r;
  logic [OW-1:0]           s2_dy_r;
  logic [7:0]              s2_top_r [3];
  logic [7:0]              s2_bot_r [3];
  // stage 3: vertical product
  logic                    s3_v_r, s3_last_r;
  logic [11:0]             s3_x_r, s3_y_r;
  logic [7:0]              s3_top_r [3];
  logic signed [10:0]      s3_m_r [3];
  // stage 4: output register
  logic                    s4_v_r, s4_last_r;
  logic [11:0]             s4_x_r, s4_y_r;
  logic [7:0]              s4_chan_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= cmd.issue;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [10:0] da, dc, dv;
    logic signed [9:0]  tv, bv, ov;
    if (adv) begin
      s1_last_r <= cmd.last;
      s1_x_r    <= x_full[11:0];
      s1_y_r    <= y_full[11:0];
      s1_dy_r   <= cmd.dy;
      s2_last_r <= s1_last_r;
      s2_x_r    <= s1_x_r;
      s2_y_r    <= s1_y_r;
      s2_dy_r   <= s1_dy_r;
      s3_last_r <= s2_last_r;
      s3_x_r    <= s2_x_r;
      s3_y_r    <= s2_y_r;
      s4_last_r <= s3_last_r;
      s4_x_r    <= s3_x_r;
      s4_y_r    <= s3_y_r;
      for (int k = 0; k < 3; k++) begin
        // channel k: red in the top byte
        da = {3'b000, c01[23-8*k -: 8]} - {3'b000, c00[23-8*k -: 8]};
        dc = {3'b000, c11[23-8*k -: 8]} - {3'b000, c10[23-8*k -: 8]};
        s1_a_r[k]  <= c00[23-8*k -: 8];
        s1_c_r[k]  <= c10[23-8*k -: 8];
        s1_pb_r[k] <= $signed({{(11-OW){1'b0}}, cmd.dx}) * da;
        s1_pd_r[k] <= $signed({{(11-OW){1'b0}}, cmd.dx}) * dc;

        tv = $signed({2'b00, s1_a_r[k]}) + tdiv(s1_pb_r[k], s_eff);
        bv = $signed({2'b00, s1_c_r[k]}) + tdiv(s1_pd_r[k], s_eff);
        s2_top_r[k] <= tv[7:0];
        s2_bot_r[k] <= bv[7:0];

        dv = {3'b000, s2_bot_r[k]} - {3'b000, s2_top_r[k]};
        s3_top_r[k] <= s2_top_r[k];
        s3_m_r[k]   <= $signed({{(11-OW){1'b0}}, s2_dy_r}) * dv;

        ov = $signed({2'b00, s3_top_r[k]}) + tdiv(s3_m_r[k], s_eff);
        if (ov < 0) s4_chan_r[k] <= '0;
        else if (ov > 10'(biu_pkg::CHAN_MAX)) s4_chan_r[k] <= 8'(biu_pkg::CHAN_MAX);
        else s4_chan_r[k] <= ov[7:0];
      end
    end
  end

  assign out_valid     = s4_v_r;
  assign out_x         = s4_x_r;
  assign out_y         = s4_y_r;
  assign out_red_out   = s4_chan_r[0];
  assign out_green_out = s4_chan_r[1];
  assign out_blue_out  = s4_chan_r[2];
  assign out_run_last  = s4_last_r;

  assign stat.row_nz   = (row_cur != '0);
  assign stat.col_nz   = (col_cur != '0);
  assign stat.last_col = ({1'b0, col_cur} == w_eff - WW'(1));
  assign stat.last_row = ({1'b0, row_cur} == h_eff - 11'd1);
  assign stat.adv      = adv;
  assign stat.scale    = s_eff;

endmodule

[rtl/core/bilinear_integer_upscaler.sv]
// ----------------------------------------------------------------------------
// bilinear_integer_upscaler
// Raster-order RGB source pixels in, bilinearly enlarged pixels out.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake           | Payload
//  in      | input     | in_valid / in_stall | in_red_in, in_green_in, in_blue_in
//  out     | output    | out_valid/out_stall | out_x, out_y, out_*_out, out_run_last
//  cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Per item the sequencer walks from none up to four cells, s*s output points each, s = scale;
// it issues one output point per cycle into a 4-stage pipe while that pipe moves.
// The line buffer is read on capture, before FETCH; COMMIT writes it and steps the counters.
// out_stall with out_valid high freezes the whole pipe and the sequencer's issue.
// Reset (rst_n low, synchronous) clears counters, left and upper-left pixels and pipe
// valids; line buffer contents stay undefined until written.
// ----------------------------------------------------------------------------
`include "bilinear_integer_upscaler_defines.svh"

module bilinear_integer_upscaler #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_SCALE = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_red_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_blue_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [11:0] out_x,
  output logic [11:0] out_y,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_blue_out,
  output logic        out_run_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  biu_pkg::biu_cmd_t  cmd;
  biu_pkg::biu_stat_t stat;
  logic               cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  biu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  biu_datapath #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_SCALE (MAX_SCALE)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_red_in     (in_red_in),
    .in_green_in   (in_green_in),
    .in_blue_in    (in_blue_in),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_red_out   (out_red_out),
    .out_green_out (out_green_out),
    .out_blue_out  (out_blue_out),
    .out_run_last  (out_run_last)
  );

  // a transfer on the input side blocks the next one until the item is done
  `BIU_ASSERT_NXT(a_busy_after_in, in_valid && !in_stall, in_stall, "input taken twice")
  // points only enter the pipe when it moves
  `BIU_ASSERT_IMP(a_issue_adv, cmd.issue, stat.adv, "point issued into frozen pipe")
  // the line buffer is never read and written for the same item at once
  `BIU_ASSERT_IMP(a_cap_commit, cmd.capture, !cmd.commit && !cmd.issue, "capture overlap")

endmodule
